>>> hw/rtl/spwgw_pkg.sv
// Shared constants, types and helpers for the SPI panel GRAM writer.
package spwgw_pkg;

  // Panel geometry
  localparam int PANEL_WIDTH  = 240;
  localparam int PANEL_HEIGHT = 320;
  localparam int PIXEL_COUNT  = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int PIX_AW       = $clog2(PIXEL_COUNT);

  // Field widths
  localparam int PIX_W   = 16;
  localparam int COORD_W = 16;
  localparam int BYTE_W  = 8;

  // Command codes
  localparam logic [BYTE_W-1:0] CMD_SWRESET = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_SLPOUT  = 8'h11;
  localparam logic [BYTE_W-1:0] CMD_INVOFF  = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_INVON   = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_DISPOFF = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_DISPON  = 8'h29;
  localparam logic [BYTE_W-1:0] CMD_RAMWR   = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_CASET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_RASET   = 8'h2B;

  // Window arguments per CASET or RASET
  localparam int ARG_COUNT = 4;
  localparam int ARG_CW    = $clog2(ARG_COUNT + 1);

  // Full-panel window limits
  localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(PANEL_HEIGHT - 1);

  // Stream payload widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // Pixel memory write request
  typedef struct packed {
    logic              en;
    logic [PIX_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } gram_wr_t;

  // Display mode flags
  typedef struct packed {
    logic display_on;
    logic asleep;
    logic inverted;
  } mode_t;

  // Linear pixel address from an on-panel cursor position
  function automatic logic [PIX_AW-1:0] pixel_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
    logic [PIX_AW-1:0] base;
    base = PIX_AW'(row) * PIX_AW'(PANEL_WIDTH);
    return base + PIX_AW'(col);
  endfunction

endpackage

>>> hw/rtl/spwgw_ram.sv
// Single write port, single read port pixel memory with registered read data.
module spwgw_ram #(
  parameter int DEPTH  = 76800,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/spwgw_cmd.sv
// Command decoder: mode flags, address window, write cursor and pixel assembly.
module spwgw_cmd (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  input  logic                             data_not_command,
  input  logic [spwgw_pkg::BYTE_W-1:0]     spi_byte,
  output spwgw_pkg::gram_wr_t              gram_wr,
  output spwgw_pkg::mode_t                 mode
);
  import spwgw_pkg::*;

  logic [BYTE_W-1:0]  current_command;
  logic [BYTE_W-1:0]  arg_bytes [ARG_COUNT-1];
  logic [ARG_CW-1:0]  arg_count;
  logic [COORD_W-1:0] column_start, column_end, row_start, row_end;
  logic [COORD_W-1:0] cursor_column, cursor_row;
  logic [COORD_W-1:0] cursor_column_next, cursor_row_next;
  logic               pixel_phase;
  logic [BYTE_W-1:0]  pixel_high_byte;
  logic               asleep, display_on, inverted;

  logic is_data, is_cmd, is_window, arg_done, pixel_done, on_panel;

  assign is_data   = byte_valid && data_not_command;
  assign is_cmd    = byte_valid && !data_not_command;
  assign is_window = (current_command == CMD_CASET) || (current_command == CMD_RASET);
  assign arg_done  = is_data && is_window && (arg_count == ARG_CW'(ARG_COUNT - 1));
  assign pixel_done = is_data && (current_command == CMD_RAMWR) && pixel_phase;
  assign on_panel  = (cursor_column < COORD_W'(PANEL_WIDTH)) &&
                     (cursor_row < COORD_W'(PANEL_HEIGHT));

  // Advance the cursor, wrapping inside the window
  always_comb begin
    if (cursor_column >= column_end) begin
      cursor_column_next = column_start;
      cursor_row_next    = (cursor_row >= row_end) ? row_start : cursor_row + 1'b1;
    end else begin
      cursor_column_next = cursor_column + 1'b1;
      cursor_row_next    = cursor_row;
    end
  end

  // Pixel memory write, dropped off the panel
  assign gram_wr.en   = pixel_done && on_panel;
  assign gram_wr.addr = pixel_addr(cursor_row, cursor_column);
  assign gram_wr.data = {pixel_high_byte, spi_byte};

  assign mode.display_on = display_on;
  assign mode.asleep     = asleep;
  assign mode.inverted   = inverted;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= '0;
      arg_count       <= '0;
      column_start    <= '0;
      column_end      <= COL_LAST;
      row_start       <= '0;
      row_end         <= ROW_LAST;
      cursor_column   <= '0;
      cursor_row      <= '0;
      pixel_phase     <= 1'b0;
      asleep          <= 1'b1;
      display_on      <= 1'b0;
      inverted        <= 1'b0;
    end else if (is_cmd) begin
      current_command <= spi_byte;
      arg_count       <= '0;
      pixel_phase     <= 1'b0;
      unique case (spi_byte)
        CMD_SWRESET: begin
          asleep        <= 1'b1;
          display_on    <= 1'b0;
          inverted      <= 1'b0;
          column_start  <= '0;
          column_end    <= COL_LAST;
          row_start     <= '0;
          row_end       <= ROW_LAST;
          cursor_column <= '0;
          cursor_row    <= '0;
        end
        CMD_SLPOUT:  asleep     <= 1'b0;
        CMD_INVOFF:  inverted   <= 1'b0;
        CMD_INVON:   inverted   <= 1'b1;
        CMD_DISPOFF: display_on <= 1'b0;
        CMD_DISPON:  display_on <= 1'b1;
        CMD_RAMWR: begin
          cursor_column <= column_start;
          cursor_row    <= row_start;
        end
        default: ;
      endcase
    end else if (is_data) begin
      // Collect window arguments, drop any beyond the fourth
      if (is_window && (arg_count < ARG_CW'(ARG_COUNT))) begin
        arg_count <= arg_count + 1'b1;
      end
      if (arg_done && (current_command == CMD_CASET)) begin
        column_start <= {arg_bytes[0], arg_bytes[1]};
        column_end   <= {arg_bytes[2], spi_byte};
      end
      if (arg_done && (current_command == CMD_RASET)) begin
        row_start <= {arg_bytes[0], arg_bytes[1]};
        row_end   <= {arg_bytes[2], spi_byte};
      end
      // Pair bytes into pixels, high byte first
      if (current_command == CMD_RAMWR) begin
        pixel_phase <= !pixel_phase;
      end
      if (pixel_done) begin
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
      end
    end
  end

  // Argument and pixel byte holding registers
  always_ff @(posedge clk) begin
    if (is_data && is_window) begin
      for (int i = 0; i < ARG_COUNT - 1; i++) begin
        if (arg_count == ARG_CW'(i)) begin
          arg_bytes[i] <= spi_byte;
        end
      end
    end
    if (is_data && (current_command == CMD_RAMWR) && !pixel_phase) begin
      pixel_high_byte <= spi_byte;
    end
  end

  a_arg_count_max: assert property (@(posedge clk) disable iff (rst)
    arg_count <= ARG_CW'(ARG_COUNT))
    else $error("argument count past four");

  a_cmd_clears_phase: assert property (@(posedge clk) disable iff (rst)
    is_cmd |=> !pixel_phase && (arg_count == '0))
    else $error("command did not clear pixel phase or argument count");

  a_write_on_panel: assert property (@(posedge clk) disable iff (rst)
    gram_wr.en |-> (gram_wr.addr < PIX_AW'(PIXEL_COUNT)))
    else $error("pixel write beyond panel");

endmodule

>>> hw/rtl/spwgw_read.sv
// Read pipeline: blanking and inversion of the pixel read, result register.
module spwgw_read (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          read_accept,
  input  logic [spwgw_pkg::PIX_AW-1:0]  read_index,
  input  logic                          backlight_pin,
  input  spwgw_pkg::mode_t              mode,
  input  logic [spwgw_pkg::PIX_W-1:0]   rd_data,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spwgw_pkg::PIX_W-1:0]   out_pixel,
  output spwgw_pkg::mode_t              out_mode
);
  import spwgw_pkg::*;

  logic  backlight_active_low;
  logic  s1_valid, s1_show, s1_go;
  mode_t s1_mode;

  assign s1_go = s1_valid && (!out_valid || out_ready);
  assign ready = !s1_valid || s1_go;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_active_low <= 1'b1;
    end else if (cfg_wr_en) begin
      backlight_active_low <= cfg_wr_data;
    end
  end

  // Stage 1: memory read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (read_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_accept) begin
      s1_mode <= mode;
      s1_show <= mode.display_on && !mode.asleep &&
                 (backlight_pin ^ backlight_active_low) &&
                 (read_index < PIX_AW'(PIXEL_COUNT));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_pixel <= s1_show ? (rd_data ^ {PIX_W{s1_mode.inverted}}) : '0;
      out_mode  <= s1_mode;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid)
    else $error("read stage dropped while stalled");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !read_accept)
    else $error("read accepted into a stalled stage");

endmodule

>>> hw/rtl/spi_panel_window_gram_writer_unit.sv
// Top level of the SPI panel GRAM writer: stream ports, decoder, memory, read pipeline.
// Throughput: one transfer per cycle while results are taken; with a result waiting and a
//   second read in the read stage, every input transfer stalls, SPI bytes included.
// SPI byte: takes effect at its transfer edge, where a completed pixel is also written.
// Read: memory read at the transfer edge, into the read stage; the result register is loaded
//   from it once free, and tvalid rises when the result register is loaded.
// Reset (rst, synchronous): flags, window, cursor and config restored at once; the
//   pixel memory has no clearing pass and is undefined until written.
module spi_panel_window_gram_writer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // spi_byte[7:0], chip_select_n[8], reset_pin_n[9], read_index[26:10],
  // backlight_pin[27], zero[31:28]
  input  logic [spwgw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // action[0], data_not_command[1]
  input  logic [spwgw_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_value[15:0], display_enabled[16], sleep_mode[17], invert_mode[18], zero[23:19]
  output logic [spwgw_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import spwgw_pkg::*;

  logic              accept, byte_valid, read_accept;
  logic [BYTE_W-1:0] spi_byte;
  logic              chip_select_n, reset_pin_n, backlight_pin;
  logic [PIX_AW-1:0] read_index;
  gram_wr_t          gram_wr;
  mode_t             mode, out_mode;
  logic [PIX_W-1:0]  rd_data, out_pixel;

  // Unpack the input transfer
  assign spi_byte      = s_axis_tdata[7:0];
  assign chip_select_n = s_axis_tdata[8];
  assign reset_pin_n   = s_axis_tdata[9];
  assign read_index    = s_axis_tdata[10 +: PIX_AW];
  assign backlight_pin = s_axis_tdata[27];

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign byte_valid  = accept && !s_axis_tuser[0] && !chip_select_n && reset_pin_n;
  assign read_accept = accept && s_axis_tuser[0];

  spwgw_cmd u_cmd (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .data_not_command (s_axis_tuser[1]),
    .spi_byte         (spi_byte),
    .gram_wr          (gram_wr),
    .mode             (mode)
  );

  spwgw_ram #(
    .DEPTH  (PIXEL_COUNT),
    .DATA_W (PIX_W),
    .ADDR_W (PIX_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (gram_wr.en),
    .wr_addr (gram_wr.addr),
    .wr_data (gram_wr.data),
    .rd_en   (read_accept),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  spwgw_read u_read (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .read_accept   (read_accept),
    .read_index    (read_index),
    .backlight_pin (backlight_pin),
    .mode          (mode),
    .rd_data       (rd_data),
    .ready         (s_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_pixel     (out_pixel),
    .out_mode      (out_mode)
  );

  // Pack the result transfer
  assign m_axis_tdata = {5'b0, out_mode.inverted, out_mode.asleep, out_mode.display_on,
                         out_pixel};

endmodule

>>> tb/tb_spi_panel_window_gram_writer_unit.sv
// Self-checking testbench for the SPI panel GRAM writer: stream stimulus, panel predictor, scoreboard.
module tb_spi_panel_window_gram_writer_unit;
  import spwgw_pkg::*;

  // Item codes on the slave side
  localparam bit ACT_SPI    = 1'b0;
  localparam bit ACT_READ   = 1'b1;
  localparam bit DC_COMMAND = 1'b0;
  localparam bit DC_DATA    = 1'b1;
  // A command code the block does not decode (memory access control on real panels)
  localparam logic [BYTE_W-1:0] CMD_UNLISTED = 8'h36;

  localparam int INDEX_MAX       = (1 << 17) - 1;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int REPORT_CAP      = 50;

  typedef struct {
    bit          act;
    bit [7:0]    spi_byte;
    bit          dc;
    bit          cs_n;
    bit          rst_n;
    bit [16:0]   idx;
    bit          bl;
  } panel_item_t;

  typedef struct {
    bit [15:0] pixel;
    bit        disp_on;
    bit        asleep;
    bit        inv;
  } readout_t;

  // Panel predictor and store of expected pixel readouts
  class gram_scoreboard;
    bit [15:0]   gram [int];
    int          written_pixels[$];
    readout_t    pending[$];
    bit [7:0]    cmd;
    bit [7:0]    args [ARG_COUNT];
    int          arg_cnt;
    bit [15:0]   col_lo, col_hi, row_lo, row_hi;
    bit [15:0]   col, row;
    bit          half_pending;
    bit [7:0]    hi_byte;
    bit          asleep, disp_on, inv;
    bit          bl_active_low;
    int          errors;

    function new();
      cmd = '0;
      arg_cnt = 0;
      col_lo = '0;
      col_hi = COL_LAST;
      row_lo = '0;
      row_hi = ROW_LAST;
      col = '0;
      row = '0;
      half_pending = 1'b0;
      hi_byte = '0;
      asleep = 1'b1;
      disp_on = 1'b0;
      inv = 1'b0;
      bl_active_low = 1'b1;
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < REPORT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Advance the panel state for one accepted transfer
    function void note_transfer(input panel_item_t it);
      bit        light;
      bit [15:0] pix;
      readout_t  r;
      int        addr;
      if (it.act == ACT_READ) begin
        light = bl_active_low ? !it.bl : it.bl;
        pix = '0;
        if (disp_on && !asleep && light && it.idx < PIXEL_COUNT) begin
          if (gram.exists(int'(it.idx))) pix = gram[int'(it.idx)];
          if (inv) pix = ~pix;
        end
        r.pixel = pix;
        r.disp_on = disp_on;
        r.asleep = asleep;
        r.inv = inv;
        pending.push_back(r);
      end else if (!it.cs_n && it.rst_n) begin
        if (it.dc == DC_COMMAND) begin
          cmd = it.spi_byte;
          arg_cnt = 0;
          half_pending = 1'b0;
          case (it.spi_byte)
            CMD_SWRESET: begin
              asleep = 1'b1;
              disp_on = 1'b0;
              inv = 1'b0;
              col_lo = '0;
              col_hi = COL_LAST;
              row_lo = '0;
              row_hi = ROW_LAST;
              col = '0;
              row = '0;
            end
            CMD_SLPOUT:  asleep = 1'b0;
            CMD_INVOFF:  inv = 1'b0;
            CMD_INVON:   inv = 1'b1;
            CMD_DISPOFF: disp_on = 1'b0;
            CMD_DISPON:  disp_on = 1'b1;
            CMD_RAMWR: begin
              col = col_lo;
              row = row_lo;
            end
            default: ;
          endcase
        end else if (cmd == CMD_CASET || cmd == CMD_RASET) begin
          // Collect four big-endian bytes, drop any surplus
          if (arg_cnt < ARG_COUNT) begin
            args[arg_cnt] = it.spi_byte;
            arg_cnt++;
            if (arg_cnt == ARG_COUNT) begin
              if (cmd == CMD_CASET) begin
                col_lo = {args[0], args[1]};
                col_hi = {args[2], args[3]};
              end else begin
                row_lo = {args[0], args[1]};
                row_hi = {args[2], args[3]};
              end
            end
          end
        end else if (cmd == CMD_RAMWR) begin
          if (!half_pending) begin
            hi_byte = it.spi_byte;
            half_pending = 1'b1;
          end else begin
            half_pending = 1'b0;
            // Store on-panel pixels only, then step the cursor through the window
            if (col < PANEL_WIDTH && row < PANEL_HEIGHT) begin
              addr = int'(row) * PANEL_WIDTH + int'(col);
              if (!gram.exists(addr)) written_pixels.push_back(addr);
              gram[addr] = {hi_byte, it.spi_byte};
            end
            if (col >= col_hi) begin
              col = col_lo;
              row = (row >= row_hi) ? row_lo : row + 16'd1;
            end else begin
              col = col + 16'd1;
            end
          end
        end
      end
    endfunction

    // Compare one accepted result with the oldest expected readout
    task check_readout(input bit [M_TDATA_W-1:0] word);
      readout_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with no read pending", word));
        return;
      end
      want = pending.pop_front();
      if (word[15:0] != want.pixel)
        report($sformatf("pixel_value %h, expected %h", word[15:0], want.pixel));
      if (word[16] != want.disp_on)
        report($sformatf("display_enabled %0b, expected %0b", word[16], want.disp_on));
      if (word[17] != want.asleep)
        report($sformatf("sleep_mode %0b, expected %0b", word[17], want.asleep));
      if (word[18] != want.inv)
        report($sformatf("invert_mode %0b, expected %0b", word[18], want.inv));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  gram_scoreboard sb;
  bit             quiet_stretch = 1'b0;
  int             items_sent = 0;
  int             cycle_count = 0;

  spi_panel_window_gram_writer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // SPI byte with don't-care read fields randomised
  function automatic panel_item_t spi_item(input bit dc, input bit [7:0] b);
    panel_item_t it;
    it.act = ACT_SPI;
    it.spi_byte = b;
    it.dc = dc;
    it.cs_n = 1'b0;
    it.rst_n = 1'b1;
    it.idx = 17'($urandom);
    it.bl = 1'($urandom);
    return it;
  endfunction

  // Pixel read with don't-care byte fields randomised
  function automatic panel_item_t read_item(input int idx, input bit bl);
    panel_item_t it;
    it.act = ACT_READ;
    it.spi_byte = 8'($urandom);
    it.dc = 1'($urandom);
    it.cs_n = 1'($urandom);
    it.rst_n = 1'($urandom);
    it.idx = 17'(idx);
    it.bl = bl;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input panel_item_t it);
    int gap;
    gap = quiet_stretch ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {4'b0, it.bl, it.idx, it.rst_n, it.cs_n, it.spi_byte};
    s_axis_tuser <= {it.dc, it.act};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    sb.note_transfer(it);
    if (it.act == ACT_READ || (!it.cs_n && it.rst_n)) items_sent++;
  endtask

  task automatic send_cmd(input bit [7:0] code);
    send_item(spi_item(DC_COMMAND, code));
  endtask

  task automatic send_data(input bit [7:0] b);
    send_item(spi_item(DC_DATA, b));
  endtask

  // Window command with its arguments, sometimes cut short or with surplus bytes
  task automatic send_window(input bit [7:0] code, input bit [15:0] lo, input bit [15:0] hi);
    bit [31:0] packed_args;
    int        cnt;
    int        pick;
    packed_args = {lo, hi};
    pick = $urandom_range(0, 9);
    cnt = (pick == 0) ? $urandom_range(0, 3) : (pick == 1) ? $urandom_range(5, 6) : 4;
    send_cmd(code);
    for (int i = 0; i < cnt; i++)
      send_data((i < 4) ? packed_args[31 - 8 * i -: 8] : 8'($urandom));
  endtask

  // Hold the sender until every readout has arrived, then let the pipeline settle
  task automatic await_readouts();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_backlight_polarity(input bit active_low);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= active_low;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.bl_active_low = active_low;
  endtask

  // One random sequence: mostly window writes and reads, with mode changes and noise
  task automatic random_burst();
    int          pick, n;
    bit [15:0]   lo, hi, rlo, rhi;
    bit [7:0]    code;
    panel_item_t it;
    quiet_stretch = ($urandom_range(0, 4) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      lo = 16'($urandom_range(0, PANEL_WIDTH - 1));
      hi = lo + 16'($urandom_range(0, 3));
      rlo = 16'($urandom_range(0, PANEL_HEIGHT - 1));
      rhi = rlo + 16'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        rlo = 16'($urandom);
        rhi = 16'($urandom);
      end
      send_window(CMD_CASET, lo, hi);
      send_window(CMD_RASET, rlo, rhi);
      send_cmd(CMD_RAMWR);
      n = 2 * $urandom_range(1, 10) + (($urandom_range(0, 9) == 0) ? 1 : 0);
      repeat (n) send_data(8'($urandom));
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 4)) begin
        if (sb.written_pixels.size() != 0 && $urandom_range(0, 99) < 85)
          n = sb.written_pixels[$urandom_range(0, sb.written_pixels.size() - 1)];
        else
          n = $urandom_range(PIXEL_COUNT, INDEX_MAX);
        send_item(read_item(n, 1'($urandom)));
      end
    end else if (pick < 80) begin
      // Favour commands that keep the panel lit
      n = $urandom_range(0, 99);
      code = (n < 25) ? CMD_DISPON : (n < 50) ? CMD_SLPOUT : (n < 65) ? CMD_INVON :
             (n < 80) ? CMD_INVOFF : (n < 92) ? CMD_DISPOFF : CMD_SWRESET;
      send_cmd(code);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) begin
        it = spi_item(1'($urandom), 8'($urandom));
        n = $urandom_range(0, 2);
        if (n != 1) it.cs_n = 1'b1;
        if (n != 0) it.rst_n = 1'b0;
        send_item(it);
      end
    end else if (pick < 97) begin
      send_cmd(($urandom_range(0, 1) == 0) ? CMD_UNLISTED : 8'($urandom));
      repeat ($urandom_range(0, 3)) send_data(8'($urandom));
    end else begin
      await_readouts();
    end
  endtask

  // Take results after random stalls and check them
  initial begin : result_sink
    int                   stall;
    bit [M_TDATA_W-1:0]   word;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_stretch ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      word = m_axis_tdata;
      @(posedge clk);
      sb.check_readout(word);
    end
  end

  initial begin : stimulus
    panel_item_t it;
    int          corner;
    sb = new();
    corner = (PANEL_HEIGHT - 1) * PANEL_WIDTH;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      // Switch backlight polarity only while idle
      if (p != 0) await_readouts();
      write_backlight_polarity(!p[0]);

      if (p == 0) begin
        // Blanked read off the panel, bytes dropped by CS and RST
        send_item(read_item(INDEX_MAX, 1'b0));
        it = spi_item(DC_COMMAND, CMD_DISPON);
        it.cs_n = 1'b1;
        send_item(it);
        it = spi_item(DC_COMMAND, CMD_DISPON);
        it.rst_n = 1'b0;
        send_item(it);
        send_cmd(CMD_SLPOUT);
        send_cmd(CMD_DISPON);
        // Two-column window on the last row, with one surplus argument
        send_cmd(CMD_CASET);
        send_data(8'h00);
        send_data(8'h00);
        send_data(8'h00);
        send_data(8'h01);
        send_data(8'hFF);
        send_cmd(CMD_RASET);
        send_data(ROW_LAST[15:8]);
        send_data(ROW_LAST[7:0]);
        send_data(ROW_LAST[15:8]);
        send_data(ROW_LAST[7:0]);
        send_cmd(CMD_RAMWR);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'h00);
        // Lit read, backlight off, then inverted
        send_item(read_item(corner + 1, 1'b0));
        send_item(read_item(corner, 1'b1));
        send_cmd(CMD_INVON);
        send_item(read_item(corner, 1'b0));
      end

      while (items_sent < (p + 1) * ITEMS_PER_PHASE) random_burst();
    end

    quiet_stretch = 1'b0;
    await_readouts();
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d readouts never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
